// File: src/ica_pkg.sv
// Shared types, opcodes and helpers for the integer constant ALU.
package ica_pkg;

	localparam int unsigned OpW = 6;
	localparam int unsigned DataW = 64;

	localparam logic [OpW-1:0] OP_ADD = 6'd0;
	localparam logic [OpW-1:0] OP_SUB = 6'd1;
	localparam logic [OpW-1:0] OP_NEG = 6'd2;
	localparam logic [OpW-1:0] OP_DIV = 6'd3;
	localparam logic [OpW-1:0] OP_REM = 6'd4;
	localparam logic [OpW-1:0] OP_UDIV = 6'd5;
	localparam logic [OpW-1:0] OP_UREM = 6'd6;
	localparam logic [OpW-1:0] OP_MUL = 6'd7;
	localparam logic [OpW-1:0] OP_AND = 6'd8;
	localparam logic [OpW-1:0] OP_OR = 6'd9;
	localparam logic [OpW-1:0] OP_XOR = 6'd10;
	localparam logic [OpW-1:0] OP_SAR = 6'd11;
	localparam logic [OpW-1:0] OP_SHR = 6'd12;
	localparam logic [OpW-1:0] OP_SHL = 6'd13;
	localparam logic [OpW-1:0] OP_EXTSB = 6'd14;
	localparam logic [OpW-1:0] OP_EXTUB = 6'd15;
	localparam logic [OpW-1:0] OP_EXTSH = 6'd16;
	localparam logic [OpW-1:0] OP_EXTUH = 6'd17;
	localparam logic [OpW-1:0] OP_EXTSW = 6'd18;
	localparam logic [OpW-1:0] OP_EXTUW = 6'd19;
	localparam logic [OpW-1:0] OP_CAST = 6'd20;
	localparam logic [OpW-1:0] OP_WCMP = 6'd21;
	localparam logic [OpW-1:0] OP_LCMP = 6'd31;
	localparam logic [OpW-1:0] OP_LAST = 6'd40;

	localparam logic [3:0] CMP_EQ = 4'd0;
	localparam logic [3:0] CMP_NE = 4'd1;
	localparam logic [3:0] CMP_SGE = 4'd2;
	localparam logic [3:0] CMP_SGT = 4'd3;
	localparam logic [3:0] CMP_SLE = 4'd4;
	localparam logic [3:0] CMP_SLT = 4'd5;
	localparam logic [3:0] CMP_UGE = 4'd6;
	localparam logic [3:0] CMP_UGT = 4'd7;
	localparam logic [3:0] CMP_ULE = 4'd8;
	localparam logic [3:0] CMP_ULT = 4'd9;

	localparam logic [DataW-1:0] SMIN64 = 64'h8000_0000_0000_0000;
	localparam logic [31:0] SMIN32 = 32'h8000_0000;
	localparam logic [31:0] LOW32 = 32'hffff_ffff;

	typedef struct packed {
		logic [OpW-1:0] action;
		logic wide;
		logic [DataW-1:0] left_value;
		logic [DataW-1:0] right_value;
		logic left_is_address;
		logic right_is_address;
		logic same_symbol;
	} req_t;

	typedef struct packed {
		logic [DataW-1:0] result_value;
		logic refused;
		logic result_is_address;
		logic symbol_from_right;
	} rsp_t;

	// item state carried down the pipeline
	typedef struct packed {
		logic [OpW-1:0] action;
		logic wide;
		logic refused;
		logic addr;
		logic from_right;
		logic [DataW-1:0] lv;
		logic [DataW-1:0] rv;
		logic [DataW-1:0] x;
	} ctl_t;

	function automatic logic [DataW-1:0] sext32(input logic [DataW-1:0] v);
		return {{32{v[31]}}, v[31:0]};
	endfunction

endpackage

// File: src/ica_if.sv
// Valid/ready channel carrying one item of type T.
interface ica_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: src/ica_divider.sv
// Pipelined restoring divider: one quotient bit per stage, 64 stages.
module ica_divider #(
	parameter type TAG_T = logic
) (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic in_valid,
	input logic [ica_pkg::DataW-1:0] dividend,
	input logic [ica_pkg::DataW-1:0] divisor,
	input TAG_T in_tag,
	output logic out_valid,
	output logic [ica_pkg::DataW-1:0] quotient,
	output logic [ica_pkg::DataW-1:0] remainder,
	output TAG_T out_tag
);
	localparam int unsigned W = ica_pkg::DataW;

	logic vld_s [W+1];
	logic [W-1:0] q_s [W+1];
	logic [W-1:0] r_s [W+1];
	logic [W-1:0] d_s [W+1];
	TAG_T tag_s [W+1];

	assign vld_s[0] = in_valid;
	assign q_s[0] = dividend;
	assign r_s[0] = '0;
	assign d_s[0] = divisor;
	assign tag_s[0] = in_tag;

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W:0] trial;
		logic [W:0] diff;
		assign trial = {r_s[i], q_s[i][W-1]};
		assign diff = trial - {1'b0, d_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else if (adv) begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				d_s[i+1] <= d_s[i];
				tag_s[i+1] <= tag_s[i];
				if (!diff[W]) begin
					r_s[i+1] <= diff[W-1:0];
					q_s[i+1] <= {q_s[i][W-2:0], 1'b1};
				end else begin
					r_s[i+1] <= trial[W-1:0];
					q_s[i+1] <= {q_s[i][W-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[W];
	assign quotient = q_s[W];
	assign remainder = r_s[W];
	assign out_tag = tag_s[W];
endmodule

// File: src/ica_front.sv
// Front stage: checks, operand conditioning and the simple operations.
module ica_front (
	input ica_pkg::req_t req,
	output ica_pkg::ctl_t ctl,
	output logic [ica_pkg::DataW-1:0] div_a,
	output logic [ica_pkg::DataW-1:0] div_b
);
	localparam int unsigned W = ica_pkg::DataW;

	logic [ica_pkg::OpW-1:0] op;
	logic w, la, ra, refuse, addr, from_right, cmp;
	logic [W-1:0] l, r, ls, rs, lu, ru, x, cl, cr;
	logic [5:0] sh;
	logic [3:0] k;
	logic rz, rm1, lmin, is_div, is_sdiv;

	always_comb begin
		op = req.action;
		w = req.wide;
		l = req.left_value;
		r = req.right_value;
		la = req.left_is_address;
		ra = req.right_is_address;
		addr = 1'b0;
		from_right = 1'b0;
		refuse = 1'b0;
		if (op == ica_pkg::OP_ADD) begin
			if (la && ra) refuse = 1'b1;
			else if (la) addr = 1'b1;
			else if (ra) begin
				addr = 1'b1;
				from_right = 1'b1;
			end
		end else if (op == ica_pkg::OP_SUB) begin
			if (la) begin
				if (!ra) addr = 1'b1;
				else if (!req.same_symbol) refuse = 1'b1;
			end else if (ra) refuse = 1'b1;
		end else if (la || ra) refuse = 1'b1;

		is_div = op >= ica_pkg::OP_DIV && op <= ica_pkg::OP_UREM;
		is_sdiv = op == ica_pkg::OP_DIV || op == ica_pkg::OP_REM;
		rz = w ? (r == '0) : (r[31:0] == '0);
		rm1 = w ? (r == '1) : (r[31:0] == ica_pkg::LOW32);
		lmin = w ? (l == ica_pkg::SMIN64) : (l[31:0] == ica_pkg::SMIN32);
		if (is_div && rz) refuse = 1'b1;
		if (is_sdiv && rm1 && lmin) refuse = 1'b1;
		if (op > ica_pkg::OP_LAST) refuse = 1'b1;

		ls = w ? l : ica_pkg::sext32(l);
		rs = w ? r : ica_pkg::sext32(r);
		lu = w ? l : {32'd0, l[31:0]};
		ru = w ? r : {32'd0, r[31:0]};
		sh = w ? r[5:0] : {1'b0, r[4:0]};

		// magnitudes for signed division
		div_a = (is_sdiv && ls[W-1]) ? (W'(0) - ls) : lu;
		div_b = (is_sdiv && rs[W-1]) ? (W'(0) - rs) : ru;
		if (is_sdiv) begin
			div_a = ls[W-1] ? (W'(0) - ls) : ls;
			div_b = rs[W-1] ? (W'(0) - rs) : rs;
		end

		cmp = op >= ica_pkg::OP_WCMP;
		if (op >= ica_pkg::OP_LCMP) begin
			k = 4'(op - ica_pkg::OP_LCMP);
			cl = l;
			cr = r;
		end else begin
			k = 4'(op - ica_pkg::OP_WCMP);
			cl = ica_pkg::sext32(l);
			cr = ica_pkg::sext32(r);
		end

		x = '0;
		case (op)
			ica_pkg::OP_AND: x = l & r;
			ica_pkg::OP_OR: x = l | r;
			ica_pkg::OP_XOR: x = l ^ r;
			ica_pkg::OP_SAR: x = W'($signed(ls) >>> sh);
			ica_pkg::OP_SHR: x = lu >> sh;
			ica_pkg::OP_SHL: x = l << sh;
			ica_pkg::OP_EXTSB: x = {{56{l[7]}}, l[7:0]};
			ica_pkg::OP_EXTUB: x = {56'd0, l[7:0]};
			ica_pkg::OP_EXTSH: x = {{48{l[15]}}, l[15:0]};
			ica_pkg::OP_EXTUH: x = {48'd0, l[15:0]};
			ica_pkg::OP_EXTSW: x = ica_pkg::sext32(l);
			ica_pkg::OP_EXTUW: x = {32'd0, l[31:0]};
			ica_pkg::OP_CAST: x = l;
			default: x = '0;
		endcase
		if (cmp) begin
			case (k)
				ica_pkg::CMP_EQ: x = W'(cl == cr);
				ica_pkg::CMP_NE: x = W'(cl != cr);
				ica_pkg::CMP_SGE: x = W'($signed(cl) >= $signed(cr));
				ica_pkg::CMP_SGT: x = W'($signed(cl) > $signed(cr));
				ica_pkg::CMP_SLE: x = W'($signed(cl) <= $signed(cr));
				ica_pkg::CMP_SLT: x = W'($signed(cl) < $signed(cr));
				ica_pkg::CMP_UGE: x = W'(cl >= cr);
				ica_pkg::CMP_UGT: x = W'(cl > cr);
				ica_pkg::CMP_ULE: x = W'(cl <= cr);
				default: x = W'(cl < cr);
			endcase
		end

		ctl.action = op;
		ctl.wide = w;
		ctl.refused = refuse;
		ctl.addr = addr;
		ctl.from_right = from_right;
		ctl.lv = is_sdiv ? ls : l;
		ctl.rv = is_sdiv ? rs : r;
		ctl.x = x;
	end
endmodule

// File: src/ica_back.sv
// Back stage: picks the unit result, applies width mask and refusal.
module ica_back (
	input ica_pkg::ctl_t ctl,
	input logic [ica_pkg::DataW-1:0] quotient,
	input logic [ica_pkg::DataW-1:0] remainder,
	input logic [ica_pkg::DataW-1:0] product,
	output ica_pkg::rsp_t rsp
);
	localparam int unsigned W = ica_pkg::DataW;
	logic [W-1:0] x;
	logic neg_q;

	always_comb begin
		neg_q = ctl.lv[W-1] ^ ctl.rv[W-1];
		case (ctl.action)
			ica_pkg::OP_ADD: x = ctl.lv + ctl.rv;
			ica_pkg::OP_SUB: x = ctl.lv - ctl.rv;
			ica_pkg::OP_NEG: x = W'(0) - ctl.lv;
			ica_pkg::OP_DIV: x = neg_q ? (W'(0) - quotient) : quotient;
			ica_pkg::OP_REM: x = ctl.lv[W-1] ? (W'(0) - remainder) : remainder;
			ica_pkg::OP_UDIV: x = quotient;
			ica_pkg::OP_UREM: x = remainder;
			ica_pkg::OP_MUL: x = product;
			default: x = ctl.x;
		endcase
		if (!ctl.wide) x = {32'd0, x[31:0]};
		rsp.result_value = ctl.refused ? '0 : x;
		rsp.refused = ctl.refused;
		rsp.result_is_address = !ctl.refused && ctl.addr;
		rsp.symbol_from_right = !ctl.refused && ctl.addr && ctl.from_right;
	end
endmodule

// File: src/integer_constant_alu.sv
// Top level of the integer constant ALU.
// Usage:
//   req (sink) takes one item: opcode, width flag, two 64-bit operands and
//   address tags. rsp (source) gives one result item for each input item,
//   in order. An item is moved when valid and ready are high at a clock edge.
// Path: an item crosses 68 registers, the first loaded at the accept
//   edge: the front register, two multiply stages, 64 divider stages
//   (one quotient bit each) and the output register.
// Throughput: one item per cycle unless stalled; the 64-stage restoring
//   divider sets the depth, and every item travels through it so order is kept.
// The multiplier is split into three 32x32 partial products, registered,
//   then summed in the following stage.
// Stall: the whole pipeline advances only when the output register is
//   empty or being taken; req.ready follows that, so nothing is lost or
//   repeated while rsp.ready is low.
// Reset: arst_n clears all valid bits; no item is in flight afterward.
module integer_constant_alu (
	input logic clk,
	input logic arst_n,
	ica_if.sink req,
	ica_if.source rsp
);
	localparam int unsigned W = ica_pkg::DataW;

	logic adv;
	logic vld_s1, vld_s2, vld_s3, out_vld_q;
	ica_pkg::ctl_t ctl_c, ctl_s1, ctl_s2, ctl_dv;
	logic [W-1:0] da_c, db_c, da_s1, db_s1;
	logic [W-1:0] pll_s2, prod_s3, prod_dv, quo, rem;
	logic [31:0] plh_s2, phl_s2;
	logic dv_vld;
	ica_pkg::rsp_t rsp_c, rsp_q;

	typedef struct packed {
		ica_pkg::ctl_t ctl;
		logic [W-1:0] prod;
	} dtag_t;
	dtag_t tag_in, tag_out;
	ica_pkg::ctl_t ctl_s3;

	assign adv = !out_vld_q || rsp.ready;
	assign req.ready = adv;

	ica_front u_front (
		.req (req.data),
		.ctl (ctl_c),
		.div_a (da_c),
		.div_b (db_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s1 <= req.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			out_vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1 <= ctl_c;
			da_s1 <= da_c;
			db_s1 <= db_c;
			// partial products: the high-by-high term falls off a 64-bit result
			ctl_s2 <= ctl_s1;
			pll_s2 <= {32'd0, ctl_s1.lv[31:0]} * {32'd0, ctl_s1.rv[31:0]};
			plh_s2 <= ctl_s1.lv[31:0] * ctl_s1.rv[63:32];
			phl_s2 <= ctl_s1.lv[63:32] * ctl_s1.rv[31:0];
			ctl_s3 <= ctl_s2;
			prod_s3 <= pll_s2 + {plh_s2 + phl_s2, 32'd0};
			rsp_q <= rsp_c;
		end
	end

	// dividend/divisor enter at stage 3 with product and control riding as tag
	logic [W-1:0] da_s2, db_s2, da_s3, db_s3;
	always_ff @(posedge clk) begin
		if (adv) begin
			da_s2 <= da_s1;
			db_s2 <= db_s1;
			da_s3 <= da_s2;
			db_s3 <= db_s2;
		end
	end

	assign tag_in.ctl = ctl_s3;
	assign tag_in.prod = prod_s3;

	ica_divider #(.TAG_T(dtag_t)) u_div (
		.clk (clk),
		.arst_n (arst_n),
		.adv (adv),
		.in_valid (vld_s3),
		.dividend (da_s3),
		.divisor (db_s3),
		.in_tag (tag_in),
		.out_valid (dv_vld),
		.quotient (quo),
		.remainder (rem),
		.out_tag (tag_out)
	);

	assign ctl_dv = tag_out.ctl;
	assign prod_dv = tag_out.prod;

	ica_back u_back (
		.ctl (ctl_dv),
		.quotient (quo),
		.remainder (rem),
		.product (prod_dv),
		.rsp (rsp_c)
	);

	assign rsp.valid = out_vld_q;
	assign rsp.data = rsp_q;
endmodule

// File: src/integer_constant_alu_chk.sv
// Port-level checker for the integer constant ALU, bound to the top level.
module integer_constant_alu_chk (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input ica_pkg::rsp_t out_data
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	a_ref_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.refused |->
		out_data.result_value == '0 && !out_data.result_is_address)
		else $error("refused result carries data");
	a_sym: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.symbol_from_right |-> out_data.result_is_address)
		else $error("symbol side without address result");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");
endmodule

bind integer_constant_alu integer_constant_alu_chk u_chk (
	.clk (clk),
	.arst_n (arst_n),
	.in_ready (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.out_data (rsp.data)
);

// File: verif/tb.sv
// Testbench for the integer constant ALU: directed table plus random items, scoreboard check.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NumRandom = 1200;
	localparam int unsigned StallLimit = 5000;

	typedef struct {
		ica_pkg::req_t req;
		logic known;
		ica_pkg::rsp_t rsp;
	} vec_t;

	logic clk;
	logic arst_n;
	ica_if #(ica_pkg::req_t) req ();
	ica_if #(ica_pkg::rsp_t) rsp ();

	integer_constant_alu dut (.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp));

	ica_pkg::rsp_t fold_queue[$];
	int errors;
	int idle_cycles;
	bit feed_done;
	bit hold_off;
	vec_t dir_table[$];

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] sx(input logic [63:0] v, input int bits);
		logic [63:0] m;
		m = (bits == 64) ? '1 : ((64'd1 << bits) - 64'd1);
		return (v & m) | (v[bits-1] ? ~m : 64'd0);
	endfunction

	function automatic logic cmp_fold(input logic [3:0] k, input logic [63:0] l,
			input logic [63:0] r);
		case (k)
			ica_pkg::CMP_EQ: return l == r;
			ica_pkg::CMP_NE: return l != r;
			ica_pkg::CMP_SGE: return $signed(l) >= $signed(r);
			ica_pkg::CMP_SGT: return $signed(l) > $signed(r);
			ica_pkg::CMP_SLE: return $signed(l) <= $signed(r);
			ica_pkg::CMP_SLT: return $signed(l) < $signed(r);
			ica_pkg::CMP_UGE: return l >= r;
			ica_pkg::CMP_UGT: return l > r;
			ica_pkg::CMP_ULE: return l <= r;
			default: return l < r;
		endcase
	endfunction

	function automatic ica_pkg::rsp_t fold(input ica_pkg::req_t q);
		ica_pkg::rsp_t o;
		logic w, addr, frm, bad;
		logic [63:0] l, r, ls, rs, lu, ru, x, ma, mb, t;
		int sh;
		w = q.wide;
		l = q.left_value;
		r = q.right_value;
		addr = 1'b0; frm = 1'b0; bad = 1'b0; x = '0;
		sh = w ? int'(r[5:0]) : int'(r[4:0]);
		if (q.action == ica_pkg::OP_ADD) begin
			if (q.left_is_address && q.right_is_address) bad = 1'b1;
			else if (q.left_is_address) addr = 1'b1;
			else if (q.right_is_address) begin
				addr = 1'b1; frm = 1'b1;
			end
		end else if (q.action == ica_pkg::OP_SUB) begin
			if (q.left_is_address) begin
				if (!q.right_is_address) addr = 1'b1;
				else if (!q.same_symbol) bad = 1'b1;
			end else if (q.right_is_address) bad = 1'b1;
		end else if (q.left_is_address || q.right_is_address) bad = 1'b1;
		ls = w ? l : ica_pkg::sext32(l);
		rs = w ? r : ica_pkg::sext32(r);
		lu = w ? l : {32'd0, l[31:0]};
		ru = w ? r : {32'd0, r[31:0]};
		if (!bad && q.action >= ica_pkg::OP_DIV && q.action <= ica_pkg::OP_UREM) begin
			if (ru == '0) bad = 1'b1;
			else if (q.action <= ica_pkg::OP_REM
					&& (w ? (r == '1) : (r[31:0] == ica_pkg::LOW32))
					&& (w ? (l == ica_pkg::SMIN64) : (l[31:0] == ica_pkg::SMIN32)))
				bad = 1'b1;
		end
		if (!bad && q.action > ica_pkg::OP_LAST) bad = 1'b1;
		if (!bad) begin
			ma = ls[63] ? -ls : ls;
			mb = rs[63] ? -rs : rs;
			case (q.action)
				ica_pkg::OP_ADD: x = l + r;
				ica_pkg::OP_SUB: x = l - r;
				ica_pkg::OP_NEG: x = -l;
				ica_pkg::OP_DIV: begin
					t = ma / mb;
					x = (ls[63] != rs[63]) ? -t : t;
				end
				ica_pkg::OP_REM: begin
					t = ma % mb;
					x = ls[63] ? -t : t;
				end
				ica_pkg::OP_UDIV: x = lu / ru;
				ica_pkg::OP_UREM: x = lu % ru;
				ica_pkg::OP_MUL: x = l * r;
				ica_pkg::OP_AND: x = l & r;
				ica_pkg::OP_OR: x = l | r;
				ica_pkg::OP_XOR: x = l ^ r;
				ica_pkg::OP_SAR: x = $signed(ls) >>> sh;
				ica_pkg::OP_SHR: x = lu >> sh;
				ica_pkg::OP_SHL: x = l << sh;
				ica_pkg::OP_EXTSB: x = sx(l, 8);
				ica_pkg::OP_EXTUB: x = {56'd0, l[7:0]};
				ica_pkg::OP_EXTSH: x = sx(l, 16);
				ica_pkg::OP_EXTUH: x = {48'd0, l[15:0]};
				ica_pkg::OP_EXTSW: x = ica_pkg::sext32(l);
				ica_pkg::OP_EXTUW: x = {32'd0, l[31:0]};
				ica_pkg::OP_CAST: x = l;
				default:
					if (q.action < ica_pkg::OP_LCMP)
						x = 64'(cmp_fold(4'(q.action - ica_pkg::OP_WCMP),
							ica_pkg::sext32(l), ica_pkg::sext32(r)));
					else
						x = 64'(cmp_fold(4'(q.action - ica_pkg::OP_LCMP), l, r));
			endcase
			if (!w) x[63:32] = 32'd0;
		end else begin
			addr = 1'b0; frm = 1'b0;
		end
		o.result_value = x;
		o.refused = bad;
		o.result_is_address = addr;
		o.symbol_from_right = addr && frm;
		return o;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch %s: got %h want %h", what, got, want);
		errors++;
	endtask

	function automatic logic [63:0] rand64();
		case ($urandom_range(0, 7))
			0: return 64'd0;
			1: return '1;
			2: return ica_pkg::SMIN64;
			3: return {32'd0, ica_pkg::SMIN32};
			4: return 64'($urandom_range(0, 70));
			5: return {32'd0, $urandom()};
			default: return {$urandom(), $urandom()};
		endcase
	endfunction

	function automatic ica_pkg::req_t rand_req();
		ica_pkg::req_t q;
		q.action = ($urandom_range(0, 19) == 0) ? 6'($urandom_range(41, 63))
			: 6'($urandom_range(0, 40));
		q.wide = 1'($urandom_range(0, 1));
		q.left_value = rand64();
		q.right_value = rand64();
		q.left_is_address = ($urandom_range(0, 5) == 0);
		q.right_is_address = ($urandom_range(0, 5) == 0);
		q.same_symbol = 1'($urandom_range(0, 1));
		return q;
	endfunction

	// tags: {left_is_address, right_is_address, same_symbol}
	// flags: {refused, result_is_address, symbol_from_right}
	function automatic vec_t row(input logic [5:0] a, input logic w, input logic [63:0] l,
			input logic [63:0] r, input logic [2:0] tags, input logic known,
			input logic [63:0] x, input logic [2:0] flags);
		vec_t v;
		v.req = '{a, w, l, r, tags[2], tags[1], tags[0]};
		v.known = known;
		v.rsp = '{x, flags[2], flags[1], flags[0]};
		return v;
	endfunction

	// valid stays high between back-to-back items
	task automatic offer(input ica_pkg::req_t q, input int gap);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.data <= q;
		do @(posedge clk); while (!req.ready);
	endtask

	// sender: directed table, then random
	initial begin
		ica_pkg::req_t q;
		ica_pkg::rsp_t e;
		errors = 0;
		feed_done = 0;
		req.valid = 1'b0;
		req.data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		dir_table.push_back(row(ica_pkg::OP_ADD, 1'b1, '1, 64'd1, 3'b000,
			1'b1, 64'd0, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_ADD, 1'b0, 64'hffff_ffff, 64'd2, 3'b000,
			1'b1, 64'd1, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_ADD, 1'b1, 64'd5, 64'd3, 3'b010,
			1'b1, 64'd8, 3'b011));
		dir_table.push_back(row(ica_pkg::OP_ADD, 1'b1, 64'd5, 64'd3, 3'b111,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(ica_pkg::OP_SUB, 1'b1, 64'd5, 64'd3, 3'b100,
			1'b1, 64'd2, 3'b010));
		dir_table.push_back(row(ica_pkg::OP_SUB, 1'b1, 64'd5, 64'd3, 3'b111,
			1'b1, 64'd2, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_SUB, 1'b1, 64'd5, 64'd3, 3'b110,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(ica_pkg::OP_SUB, 1'b1, 64'd5, 64'd3, 3'b011,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(ica_pkg::OP_NEG, 1'b1, 64'd1, 64'd0, 3'b000,
			1'b1, '1, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_DIV, 1'b1, 64'd7, 64'd0, 3'b000,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(ica_pkg::OP_UREM, 1'b0, 64'd7, 64'h1_0000_0000, 3'b000,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(ica_pkg::OP_DIV, 1'b1, ica_pkg::SMIN64, '1, 3'b000,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(ica_pkg::OP_REM, 1'b0, 64'h8000_0000, 64'hffff_ffff, 3'b000,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(ica_pkg::OP_DIV, 1'b1, -64'sd7, 64'd2, 3'b000,
			1'b1, -64'sd3, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_REM, 1'b1, -64'sd7, 64'd2, 3'b000,
			1'b1, '1, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_MUL, 1'b1, '1, '1, 3'b000,
			1'b0, 64'd0, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_SAR, 1'b0, 64'h8000_0000, 64'd63, 3'b000,
			1'b1, 64'hffff_ffff, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_SHL, 1'b1, 64'd1, 64'd63, 3'b000,
			1'b1, ica_pkg::SMIN64, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_SHR, 1'b1, '1, 64'h7f, 3'b000,
			1'b1, 64'd1, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_EXTSB, 1'b1, 64'h80, 64'd0, 3'b000,
			1'b1, 64'hffff_ffff_ffff_ff80, 3'b000));
		dir_table.push_back(row(ica_pkg::OP_CAST, 1'b1, 64'd5, 64'd0, 3'b100,
			1'b1, 64'd0, 3'b100));
		dir_table.push_back(row(6'(ica_pkg::OP_WCMP + ica_pkg::CMP_SLT), 1'b1,
			64'h8000_0000, 64'd0, 3'b000, 1'b1, 64'd1, 3'b000));
		dir_table.push_back(row(6'(ica_pkg::OP_LCMP + ica_pkg::CMP_ULT), 1'b1,
			64'd0, '1, 3'b000, 1'b1, 64'd1, 3'b000));
		dir_table.push_back(row(6'(ica_pkg::OP_LAST + 6'd1), 1'b1, 64'd0, 64'd0, 3'b000,
			1'b1, 64'd0, 3'b100));
		foreach (dir_table[i]) begin
			e = fold(dir_table[i].req);
			if (dir_table[i].known && e != dir_table[i].rsp)
				report("table row", 64'(i), e.result_value);
			fold_queue.push_back(dir_table[i].known ? dir_table[i].rsp : e);
			offer(dir_table[i].req, $urandom_range(0, 18));
		end
		for (int n = 0; n < NumRandom; n++) begin
			q = rand_req();
			fold_queue.push_back(fold(q));
			// burst with no gaps during the long receiver hold-off
			offer(q, hold_off ? 0 : $urandom_range(0, 18));
		end
		req.valid <= 1'b0;
		feed_done = 1;
	end

	// receiver
	initial begin
		ica_pkg::rsp_t e;
		int got;
		int gap;
		rsp.ready = 1'b0;
		hold_off = 0;
		got = 0;
		@(posedge arst_n);
		forever begin
			if (got == 300) begin
				hold_off = 1;
				rsp.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			gap = $urandom_range(0, 18);
			if (gap > 0) begin
				rsp.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			rsp.ready <= 1'b1;
			do @(posedge clk); while (!rsp.valid);
			got++;
			if (fold_queue.size() == 0) begin
				report("unexpected item", rsp.data.result_value, 64'd0);
			end else begin
				e = fold_queue.pop_front();
				if (rsp.data.result_value !== e.result_value)
					report("result_value", rsp.data.result_value, e.result_value);
				if (rsp.data.refused !== e.refused)
					report("refused", 64'(rsp.data.refused), 64'(e.refused));
				if (rsp.data.result_is_address !== e.result_is_address)
					report("result_is_address", 64'(rsp.data.result_is_address),
						64'(e.result_is_address));
				if (rsp.data.symbol_from_right !== e.symbol_from_right)
					report("symbol_from_right", 64'(rsp.data.symbol_from_right),
						64'(e.symbol_from_right));
			end
		end
	end

	// watchdog and end of run
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= StallLimit) begin
				$display("Some tests failed");
				$finish;
			end
			if (feed_done && fold_queue.size() == 0) begin
				repeat (200) @(posedge clk);
				if (errors == 0 && !rsp.valid)
					$display("All tests passed");
				else
					$display("Some tests failed");
				$finish;
			end
		end
	end

endmodule

// File: files.f
src/ica_pkg.sv
src/ica_if.sv
src/ica_divider.sv
src/ica_front.sv
src/ica_back.sv
src/integer_constant_alu.sv
src/integer_constant_alu_chk.sv
verif/tb.sv
